FILE: rtl/qvr_pkg.sv
// Shared widths, sideband types and helper for the quaternion vector rotate pipeline.
// No dependencies; every other file refers to it by scoped names.
package qvr_pkg;

  localparam int COMP_W     = 32;
  localparam int UNIT_FRAC  = COMP_W - 2;
  localparam int SH_W       = $clog2(COMP_W);
  localparam int SQ_W       = 2 * COMP_W;
  localparam int SUM_W      = SQ_W + 1;
  localparam int ROOT_W     = COMP_W + 1;
  localparam int ISQ_STAGES = ROOT_W;
  localparam int NUM_W      = 2 * COMP_W - 1;
  localparam int QUOT_W     = COMP_W - 1;
  localparam int DIV_STAGES = QUOT_W + 1;
  localparam int UQ_W       = QUOT_W + 1;
  localparam int C_W        = 2 * UQ_W;
  localparam int M_W        = C_W - UNIT_FRAC;
  localparam int P_W        = M_W + COMP_W;
  localparam int T_W        = P_W + 2;
  localparam int R_W        = T_W - (UNIT_FRAC - 1);
  localparam int O_W        = R_W + 1;
  localparam int R_STAGES   = 8;

  // component positions
  localparam int QX = 0;
  localparam int QY = 1;
  localparam int QZ = 2;
  localparam int QW = 3;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [COMP_W-1:0]        mag_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             last;
    logic [3:0]       neg;
    comp_t [2:0]      v;
  } rside_t;

  typedef struct packed {
    rside_t           side;
    mag_t [3:0]       mg;
  } nside_t;

  // left shift that brings the leading one up to bit COMP_W-2 (none if it is already there or higher)
  function automatic logic [SH_W-1:0] lead_shift(mag_t a);
    logic [SH_W-1:0] sh;
    sh = '0;
    for (int i = 0; i < COMP_W; i++) begin
      if (a[i]) sh = (i >= COMP_W - 2) ? '0 : SH_W'(COMP_W - 2 - i);
    end
    return sh;
  endfunction

endpackage

FILE: rtl/qvr_prescale.sv
// Front end: component magnitudes, common prescale shift, squares and their sum.
// Depends on qvr_pkg.
module qvr_prescale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  qvr_pkg::comp_t [3:0]         quat_i,
  input  qvr_pkg::comp_t [2:0]         vec_i,
  input  logic                         last_i,
  output logic [qvr_pkg::SUM_W-1:0]    sum_o,
  output qvr_pkg::nside_t              side_o
);

  qvr_pkg::nside_t side1_d, side1_q, side2_d, side2_q, side3_d, side3_q, side4_q, side5_q;
  qvr_pkg::mag_t                   or1_d, or1_q;
  logic [qvr_pkg::SH_W-1:0]        sh2_q;
  logic [qvr_pkg::SQ_W-1:0]        sq4_q [4];
  logic [qvr_pkg::SUM_W-1:0]       sum5_q;

  always_comb begin
    side1_d            = '0;
    side1_d.side.valid = valid_i;
    side1_d.side.last  = last_i;
    side1_d.side.v     = vec_i;
    or1_d              = '0;
    for (int i = 0; i < 4; i++) begin
      side1_d.side.neg[i] = quat_i[i][qvr_pkg::COMP_W-1];
      side1_d.mg[i] = quat_i[i][qvr_pkg::COMP_W-1] ? qvr_pkg::mag_t'(-quat_i[i])
                                                   : qvr_pkg::mag_t'(quat_i[i]);
      or1_d = or1_d | side1_d.mg[i];
    end
  end

  always_comb begin
    side2_d           = side1_q;
    side2_d.side.zero = (or1_q == '0);
  end

  always_comb begin
    side3_d = side2_q;
    for (int i = 0; i < 4; i++) side3_d.mg[i] = side2_q.mg[i] << sh2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (en_i) begin
      side1_q <= side1_d;
      side2_q <= side2_d;
      side3_q <= side3_d;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or1_q  <= or1_d;
      sh2_q  <= qvr_pkg::lead_shift(or1_q);
      for (int i = 0; i < 4; i++) sq4_q[i] <= side3_q.mg[i] * side3_q.mg[i];
      sum5_q <= qvr_pkg::SUM_W'(sq4_q[0]) + qvr_pkg::SUM_W'(sq4_q[1])
              + qvr_pkg::SUM_W'(sq4_q[2]) + qvr_pkg::SUM_W'(sq4_q[3]);
    end
  end

  assign sum_o  = sum5_q;
  assign side_o = side5_q;

endmodule

FILE: rtl/qvr_isqrt.sv
// Pipelined integer square root, one root bit per stage (floor of sqrt).
// Depends on qvr_pkg.
module qvr_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [qvr_pkg::SUM_W-1:0]     sum_i,
  output logic [qvr_pkg::ROOT_W-1:0]    root_o
);

  localparam int REM_W = qvr_pkg::ROOT_W + 3;
  localparam int SR_W  = 2 * qvr_pkg::ROOT_W;

  logic [REM_W-1:0]           rem_q   [qvr_pkg::ISQ_STAGES];
  logic [qvr_pkg::ROOT_W-1:0] root_q  [qvr_pkg::ISQ_STAGES];
  logic [SR_W-1:0]            srest_q [qvr_pkg::ISQ_STAGES];

  for (genvar k = 0; k < qvr_pkg::ISQ_STAGES; k++) begin : g_stage
    logic [REM_W-1:0]           rem_in, rem_sh, trial, rem_d;
    logic [qvr_pkg::ROOT_W-1:0] root_in;
    logic [SR_W-1:0]            srest_in;
    logic                       ge;

    if (k == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign srest_in = SR_W'(sum_i);
    end else begin : g_next
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign srest_in = srest_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], srest_in[SR_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]   <= rem_d;
        root_q[k]  <= {root_in[qvr_pkg::ROOT_W-2:0], ge};
        srest_q[k] <= {srest_in[SR_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[qvr_pkg::ISQ_STAGES-1];

endmodule

FILE: rtl/qvr_udiv.sv
// Pipelined restoring divider: round(mag * 2^UNIT_FRAC / den), one quotient bit per stage.
// Depends on qvr_pkg.
module qvr_udiv (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  qvr_pkg::mag_t                 mag_i,
  input  logic [qvr_pkg::ROOT_W-1:0]    den_i,
  output logic [qvr_pkg::QUOT_W-1:0]    quot_o
);

  localparam int DREM_W = qvr_pkg::ROOT_W + 1;

  logic [DREM_W-1:0]          rem_q  [qvr_pkg::DIV_STAGES];
  logic [qvr_pkg::QUOT_W-1:0] low_q  [qvr_pkg::DIV_STAGES];
  logic [qvr_pkg::QUOT_W-1:0] quot_q [qvr_pkg::DIV_STAGES];
  logic [qvr_pkg::ROOT_W-1:0] den_q  [qvr_pkg::DIV_STAGES];
  logic [qvr_pkg::NUM_W-1:0]  num_d;

  // half the divisor is folded in for round-half-up; the quotient never exceeds QUOT_W bits,
  // so the top part of the numerator already sits below the divisor
  assign num_d = qvr_pkg::NUM_W'({mag_i, {qvr_pkg::UNIT_FRAC{1'b0}}})
               + qvr_pkg::NUM_W'(den_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DREM_W'(num_d[qvr_pkg::NUM_W-1:qvr_pkg::QUOT_W]);
      low_q[0]  <= num_d[qvr_pkg::QUOT_W-1:0];
      quot_q[0] <= '0;
      den_q[0]  <= den_i;
    end
  end

  for (genvar k = 1; k < qvr_pkg::DIV_STAGES; k++) begin : g_stage
    logic [DREM_W-1:0] rem_sh, rem_d;
    logic              ge;

    assign rem_sh = {rem_q[k-1][DREM_W-2:0], low_q[k-1][qvr_pkg::QUOT_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_q[k-1]});
    assign rem_d  = ge ? rem_sh - {1'b0, den_q[k-1]} : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= {low_q[k-1][qvr_pkg::QUOT_W-2:0], 1'b0};
        quot_q[k] <= {quot_q[k-1][qvr_pkg::QUOT_W-2:0], ge};
        den_q[k]  <= den_q[k-1];
      end
    end
  end

  assign quot_o = quot_q[qvr_pkg::DIV_STAGES-1];

endmodule

FILE: rtl/qvr_rotate.sv
// Back end: signed unit quaternion, rotation matrix, matrix-vector product, rounding,
// saturation and the final output register. Depends on qvr_pkg.
module qvr_rotate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic [3:0][qvr_pkg::QUOT_W-1:0]      quot_i,
  input  qvr_pkg::rside_t                      side_i,
  output qvr_pkg::comp_t [2:0]                 out_o,
  output logic                                 zero_o,
  output logic                                 sat_o,
  output logic                                 last_o,
  output logic                                 valid_o
);

  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;
  localparam int PXW = 6;
  localparam int PYW = 7;
  localparam int PZW = 8;

  localparam logic signed [qvr_pkg::C_W-1:0] HALF_U =
    qvr_pkg::C_W'(1) << (qvr_pkg::UNIT_FRAC - 1);
  localparam logic signed [qvr_pkg::T_W-1:0] HALF_T =
    qvr_pkg::T_W'(1) << (qvr_pkg::UNIT_FRAC - 2);
  localparam logic signed [qvr_pkg::O_W-1:0] HI_LIM =
    $signed(qvr_pkg::O_W'({1'b0, {(qvr_pkg::COMP_W-1){1'b1}}}));
  localparam logic signed [qvr_pkg::O_W-1:0] LO_LIM = -HI_LIM - qvr_pkg::O_W'(1);

  qvr_pkg::rside_t                  side_q [qvr_pkg::R_STAGES];
  logic signed [qvr_pkg::UQ_W-1:0]  u0_q  [4];
  logic signed [qvr_pkg::C_W-1:0]   p1_q  [9];
  logic signed [qvr_pkg::C_W-1:0]   c2_q  [9];
  logic signed [qvr_pkg::M_W-1:0]   m3_q  [9];
  logic signed [qvr_pkg::P_W-1:0]   mv4_q [9];
  logic signed [qvr_pkg::T_W-1:0]   t5_q  [3];
  logic signed [qvr_pkg::R_W-1:0]   r6_q  [3];
  qvr_pkg::comp_t [2:0]             out7_q;
  logic                             sat7_q;

  logic signed [qvr_pkg::C_W-1:0]   cr_d  [9];
  logic signed [qvr_pkg::T_W-1:0]   tr_d  [3];
  logic signed [qvr_pkg::O_W-1:0]   o_d   [3];
  qvr_pkg::comp_t [2:0]             out7_d;
  logic                             sat7_d;

  always_comb begin
    for (int k = 0; k < 9; k++) cr_d[k] = c2_q[k] + HALF_U;
    for (int i = 0; i < 3; i++) tr_d[i] = t5_q[i] + HALF_T;
  end

  always_comb begin
    sat7_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      o_d[i] = qvr_pkg::O_W'($signed(side_q[6].v[i])) + qvr_pkg::O_W'(r6_q[i]);
      if (o_d[i] > HI_LIM) begin
        out7_d[i] = qvr_pkg::COMP_W'(HI_LIM);
        sat7_d    = 1'b1;
      end else if (o_d[i] < LO_LIM) begin
        out7_d[i] = qvr_pkg::COMP_W'(LO_LIM);
        sat7_d    = 1'b1;
      end else begin
        out7_d[i] = qvr_pkg::COMP_W'(o_d[i]);
      end
    end
    if (side_q[6].zero) begin
      out7_d = '0;
      sat7_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qvr_pkg::R_STAGES; k++) side_q[k] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < qvr_pkg::R_STAGES; k++) side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        u0_q[i] <= side_i.neg[i] ? -$signed({1'b0, quot_i[i]}) : $signed({1'b0, quot_i[i]});
      end

      p1_q[PXX] <= u0_q[qvr_pkg::QX] * u0_q[qvr_pkg::QX];
      p1_q[PYY] <= u0_q[qvr_pkg::QY] * u0_q[qvr_pkg::QY];
      p1_q[PZZ] <= u0_q[qvr_pkg::QZ] * u0_q[qvr_pkg::QZ];
      p1_q[PXY] <= u0_q[qvr_pkg::QX] * u0_q[qvr_pkg::QY];
      p1_q[PXZ] <= u0_q[qvr_pkg::QX] * u0_q[qvr_pkg::QZ];
      p1_q[PYZ] <= u0_q[qvr_pkg::QY] * u0_q[qvr_pkg::QZ];
      p1_q[PXW] <= u0_q[qvr_pkg::QX] * u0_q[qvr_pkg::QW];
      p1_q[PYW] <= u0_q[qvr_pkg::QY] * u0_q[qvr_pkg::QW];
      p1_q[PZW] <= u0_q[qvr_pkg::QZ] * u0_q[qvr_pkg::QW];

      // matrix entries, row-major
      c2_q[0] <= -(p1_q[PYY] + p1_q[PZZ]);
      c2_q[1] <= p1_q[PXY] - p1_q[PZW];
      c2_q[2] <= p1_q[PYW] + p1_q[PXZ];
      c2_q[3] <= p1_q[PZW] + p1_q[PXY];
      c2_q[4] <= -(p1_q[PXX] + p1_q[PZZ]);
      c2_q[5] <= p1_q[PYZ] - p1_q[PXW];
      c2_q[6] <= p1_q[PXZ] - p1_q[PYW];
      c2_q[7] <= p1_q[PXW] + p1_q[PYZ];
      c2_q[8] <= -(p1_q[PXX] + p1_q[PYY]);

      for (int k = 0; k < 9; k++) begin
        m3_q[k] <= cr_d[k][qvr_pkg::C_W-1:qvr_pkg::UNIT_FRAC];
      end

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          mv4_q[3*i+j] <= m3_q[3*i+j] * $signed(side_q[3].v[j]);
        end
      end

      for (int i = 0; i < 3; i++) begin
        t5_q[i] <= qvr_pkg::T_W'(mv4_q[3*i]) + qvr_pkg::T_W'(mv4_q[3*i+1])
                 + qvr_pkg::T_W'(mv4_q[3*i+2]);
        r6_q[i] <= tr_d[i][qvr_pkg::T_W-1:qvr_pkg::UNIT_FRAC-1];
      end

      out7_q <= out7_d;
      sat7_q <= sat7_d;
    end
  end

  assign out_o   = out7_q;
  assign sat_o   = sat7_q;
  assign zero_o  = side_q[qvr_pkg::R_STAGES-1].zero;
  assign last_o  = side_q[qvr_pkg::R_STAGES-1].last;
  assign valid_o = side_q[qvr_pkg::R_STAGES-1].valid;

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_o |-> out_o == '0 && !sat_o)
    else $error("zero quaternion item left nonzero output or saturation flag");

  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && sat_o |->
      out_o[0] == qvr_pkg::COMP_W'(HI_LIM) || out_o[0] == qvr_pkg::COMP_W'(LO_LIM) ||
      out_o[1] == qvr_pkg::COMP_W'(HI_LIM) || out_o[1] == qvr_pkg::COMP_W'(LO_LIM) ||
      out_o[2] == qvr_pkg::COMP_W'(HI_LIM) || out_o[2] == qvr_pkg::COMP_W'(LO_LIM))
    else $error("saturation flagged but no component on a rail");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(out_o) && $stable(valid_o) && $stable(sat_o) && $stable(last_o))
    else $error("output stage moved while pipeline was frozen");

endmodule

FILE: rtl/quaternion_vector_rotate_core.sv
// Quaternion vector rotation core: one item per clock while no result is held by stall_i.
// Depends on qvr_pkg, qvr_prescale, qvr_isqrt, qvr_udiv and qvr_rotate.
//
// Each item carries a quaternion (Q1.30) and a vector (Q15.16); the result is the vector
// rotated by the normalized quaternion, saturated to 32 bits, with a zero-quaternion flag,
// a saturation flag and the last marker passed through. The block accepts a new item every
// cycle unless stall_i holds a result. Stages: one input register, five prescale/square
// stages, 33 of the bit-per-stage square root, 32 of the four parallel bit-per-stage dividers
// and eight rotation stages ending in the output register. The whole pipeline advances
// together; while a result is held by stall_i every stage freezes and stall_o is raised.
module quaternion_vector_rotate_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                stall_o,
  input  logic signed [qvr_pkg::COMP_W-1:0]   quat_x_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   quat_y_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   quat_z_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   quat_w_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   vec_x_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   vec_y_i,
  input  logic signed [qvr_pkg::COMP_W-1:0]   vec_z_i,
  input  logic                                last_in_i,
  output logic                                valid_o,
  input  logic                                stall_i,
  output logic signed [qvr_pkg::COMP_W-1:0]   out_x_o,
  output logic signed [qvr_pkg::COMP_W-1:0]   out_y_o,
  output logic signed [qvr_pkg::COMP_W-1:0]   out_z_o,
  output logic                                zero_quat_o,
  output logic                                saturated_o,
  output logic                                last_out_o
);

  logic                                en;
  logic                                in_valid_q;
  qvr_pkg::comp_t [3:0]                quat_q;
  qvr_pkg::comp_t [2:0]                vec_q;
  logic                                last_q;

  logic [qvr_pkg::SUM_W-1:0]           sum;
  qvr_pkg::nside_t                     ps_side;
  logic [qvr_pkg::ROOT_W-1:0]          norm;
  logic [3:0][qvr_pkg::QUOT_W-1:0]     quot;
  qvr_pkg::comp_t [2:0]                rot_out;

  qvr_pkg::nside_t                     dla_q [qvr_pkg::ISQ_STAGES];
  qvr_pkg::rside_t                     dlb_q [qvr_pkg::DIV_STAGES];

  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      quat_q[qvr_pkg::QX] <= quat_x_i;
      quat_q[qvr_pkg::QY] <= quat_y_i;
      quat_q[qvr_pkg::QZ] <= quat_z_i;
      quat_q[qvr_pkg::QW] <= quat_w_i;
      vec_q[0]            <= vec_x_i;
      vec_q[1]            <= vec_y_i;
      vec_q[2]            <= vec_z_i;
      last_q              <= last_in_i;
    end
  end

  qvr_prescale u_prescale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_q),
    .quat_i  (quat_q),
    .vec_i   (vec_q),
    .last_i  (last_q),
    .sum_o   (sum),
    .side_o  (ps_side)
  );

  qvr_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .sum_i  (sum),
    .root_o (norm)
  );

  // sideband rides alongside the root and divider pipelines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < qvr_pkg::ISQ_STAGES; k++) dla_q[k] <= '0;
      for (int k = 0; k < qvr_pkg::DIV_STAGES; k++) dlb_q[k] <= '0;
    end else if (en) begin
      dla_q[0] <= ps_side;
      for (int k = 1; k < qvr_pkg::ISQ_STAGES; k++) dla_q[k] <= dla_q[k-1];
      dlb_q[0] <= dla_q[qvr_pkg::ISQ_STAGES-1].side;
      for (int k = 1; k < qvr_pkg::DIV_STAGES; k++) dlb_q[k] <= dlb_q[k-1];
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_div
    qvr_udiv u_udiv (
      .clk_i  (clk_i),
      .en_i   (en),
      .mag_i  (dla_q[qvr_pkg::ISQ_STAGES-1].mg[i]),
      .den_i  (norm),
      .quot_o (quot[i])
    );
  end

  qvr_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .quot_i  (quot),
    .side_i  (dlb_q[qvr_pkg::DIV_STAGES-1]),
    .out_o   (rot_out),
    .zero_o  (zero_quat_o),
    .sat_o   (saturated_o),
    .last_o  (last_out_o),
    .valid_o (valid_o)
  );

  assign out_x_o = rot_out[0];
  assign out_y_o = rot_out[1];
  assign out_z_o = rot_out[2];

endmodule

FILE: tb/sv/quaternion_vector_rotate_core_tb.sv
// Self-checking testbench for quaternion_vector_rotate_core: random and directed items,
// random idle and stall, and a scoreboard that predicts each rotated vector.
// Depends on qvr_pkg and the core RTL.
module quaternion_vector_rotate_core_tb;

  typedef struct {
    qvr_pkg::comp_t qx, qy, qz, qw, vx, vy, vz;
    logic  last;
  } qvr_in_t;

  typedef struct {
    qvr_pkg::comp_t ox, oy, oz;
    logic  zero, sat, last;
  } qvr_out_t;

  class rotation_board;
    qvr_out_t expected_q[$];
    int       mismatches;

    function automatic qvr_out_t rotate_expected(qvr_in_t a);
      logic signed [127:0] q[4];
      logic signed [127:0] v[3];
      logic signed [127:0] u[4];
      logic signed [127:0] cm[3][3];
      logic signed [127:0] m[3][3];
      logic signed [127:0] t, r, o;
      logic [127:0] mg[4];
      logic [127:0] amax, s, nrm, c, um;
      logic signed [127:0] hi_lim, lo_lim;
      qvr_out_t res;
      q[0] = a.qx; q[1] = a.qy; q[2] = a.qz; q[3] = a.qw;
      v[0] = a.vx; v[1] = a.vy; v[2] = a.vz;
      res.last = a.last;
      res.ox = '0; res.oy = '0; res.oz = '0;
      res.zero = 1'b0; res.sat = 1'b0;
      amax = '0;
      for (int i = 0; i < 4; i++) begin
        mg[i] = (q[i] < 0) ? -q[i] : q[i];
        if (mg[i] > amax) amax = mg[i];
      end
      if (amax == 0) begin
        res.zero = 1'b1;
        return res;
      end
      while (amax < (128'd1 << (qvr_pkg::COMP_W - 2))) begin
        amax = amax << 1;
        for (int i = 0; i < 4; i++) mg[i] = mg[i] << 1;
      end
      s = '0;
      for (int i = 0; i < 4; i++) s = s + mg[i] * mg[i];
      nrm = '0;
      for (int b = 63; b >= 0; b--) begin
        c = nrm | (128'd1 << b);
        if (c * c <= s) nrm = c;
      end
      for (int i = 0; i < 4; i++) begin
        um = ((mg[i] << qvr_pkg::UNIT_FRAC) + (nrm >> 1)) / nrm;
        u[i] = (q[i] < 0) ? -$signed(um) : $signed(um);
      end
      // x, y, z, w at 0..3
      cm[0][0] = -(u[1] * u[1] + u[2] * u[2]);
      cm[0][1] = u[0] * u[1] - u[2] * u[3];
      cm[0][2] = u[1] * u[3] + u[0] * u[2];
      cm[1][0] = u[2] * u[3] + u[0] * u[1];
      cm[1][1] = -(u[0] * u[0] + u[2] * u[2]);
      cm[1][2] = u[1] * u[2] - u[0] * u[3];
      cm[2][0] = u[0] * u[2] - u[1] * u[3];
      cm[2][1] = u[0] * u[3] + u[1] * u[2];
      cm[2][2] = -(u[0] * u[0] + u[1] * u[1]);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = (cm[i][j] + (128'sd1 <<< (qvr_pkg::UNIT_FRAC - 1))) >>> qvr_pkg::UNIT_FRAC;
      hi_lim = (128'sd1 <<< (qvr_pkg::COMP_W - 1)) - 1;
      lo_lim = -(128'sd1 <<< (qvr_pkg::COMP_W - 1));
      for (int i = 0; i < 3; i++) begin
        t = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
        r = (t + (128'sd1 <<< (qvr_pkg::UNIT_FRAC - 2))) >>> (qvr_pkg::UNIT_FRAC - 1);
        o = v[i] + r;
        if (o > hi_lim) begin
          o = hi_lim; res.sat = 1'b1;
        end
        if (o < lo_lim) begin
          o = lo_lim; res.sat = 1'b1;
        end
        case (i)
          0: res.ox = o[qvr_pkg::COMP_W-1:0];
          1: res.oy = o[qvr_pkg::COMP_W-1:0];
          default: res.oz = o[qvr_pkg::COMP_W-1:0];
        endcase
      end
      return res;
    endfunction

    function void note_input(qvr_in_t a);
      expected_q.push_back(rotate_expected(a));
    endfunction

    function void check_result(qvr_out_t got);
      qvr_out_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item x=%0d", got.ox);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.ox !== exp_r.ox || got.oy !== exp_r.oy || got.oz !== exp_r.oz ||
          got.zero !== exp_r.zero || got.sat !== exp_r.sat || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %0d %0d %0d z%b s%b l%b got %0d %0d %0d z%b s%b l%b",
                   exp_r.ox, exp_r.oy, exp_r.oz, exp_r.zero, exp_r.sat, exp_r.last,
                   got.ox, got.oy, got.oz, got.zero, got.sat, got.last);
      end
    endfunction
  endclass

  logic  clk_i, rst_ni, valid_i, stall_o, last_in_i, valid_o, stall_i;
  qvr_pkg::comp_t quat_x_i, quat_y_i, quat_z_i, quat_w_i, vec_x_i, vec_y_i, vec_z_i;
  qvr_pkg::comp_t out_x_o, out_y_o, out_z_o;
  logic  zero_quat_o, saturated_o, last_out_o;
  logic  quiet;
  int    cycles;
  rotation_board board;

  quaternion_vector_rotate_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0; valid_i = 1'b0; stall_i = 1'b0; last_in_i = 1'b0; quiet = 1'b0;
    quat_x_i = '0; quat_y_i = '0; quat_z_i = '0; quat_w_i = '0;
    vec_x_i = '0; vec_y_i = '0; vec_z_i = '0;
    board = new();
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end
  initial cycles = 0;

  // result side: check accepted items, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o && !stall_i)
        board.check_result('{out_x_o, out_y_o, out_z_o, zero_quat_o, saturated_o, last_out_o});
      stall_i <= !quiet && ($urandom_range(99) < 14);
    end
  end

  task automatic push_item(qvr_in_t a);
    valid_i <= 1'b1;
    quat_x_i <= a.qx; quat_y_i <= a.qy; quat_z_i <= a.qz; quat_w_i <= a.qw;
    vec_x_i <= a.vx; vec_y_i <= a.vy; vec_z_i <= a.vz; last_in_i <= a.last;
    do @(posedge clk_i); while (stall_o);
    board.note_input(a);
    if (!quiet && $urandom_range(99) < 7) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic qvr_pkg::comp_t scaled_rand();
    qvr_pkg::comp_t x;
    x = qvr_pkg::comp_t'($urandom) >>> $urandom_range(31);
    return x;
  endfunction

  function automatic qvr_in_t random_item();
    qvr_in_t a;
    int kind;
    kind = $urandom_range(9);
    if (kind < 4) begin
      a.qx = $urandom; a.qy = $urandom; a.qz = $urandom; a.qw = $urandom;
    end else if (kind < 7) begin
      // tiny quaternions exercise the prescale
      a.qx = scaled_rand(); a.qy = scaled_rand(); a.qz = scaled_rand(); a.qw = scaled_rand();
    end else begin
      a.qx = $signed($urandom) >>> 2; a.qy = $signed($urandom) >>> 2;
      a.qz = $signed($urandom) >>> 2; a.qw = $signed($urandom) >>> 2;
    end
    if ($urandom_range(9) < 3) begin
      a.vx = $urandom; a.vy = $urandom; a.vz = $urandom;
    end else begin
      a.vx = scaled_rand(); a.vy = scaled_rand(); a.vz = scaled_rand();
    end
    a.last = 1'($urandom_range(1));
    if ($urandom_range(99) == 0) begin
      a.qx = '0; a.qy = '0; a.qz = '0; a.qw = '0;
    end
    return a;
  endfunction

  localparam qvr_pkg::comp_t MAXV = 32'sh7fffffff;
  localparam qvr_pkg::comp_t MINV = 32'sh80000000;
  localparam qvr_pkg::comp_t ONE  = 32'sh40000000;

  initial begin
    qvr_in_t d[$];
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    d.push_back('{0, 0, 0, 0, 100, -5, 7, 1});
    d.push_back('{0, 0, 0, 0, MAXV, MINV, 0, 0});
    d.push_back('{0, 0, 0, ONE, 32'sh10000, 32'sh20000, -32'sh30000, 0});
    d.push_back('{ONE, 0, 0, 0, MAXV, MINV, MINV, 1});
    d.push_back('{0, ONE, 0, 0, MINV, MAXV, MINV, 0});
    d.push_back('{0, 0, ONE, 0, MINV, MINV, MAXV, 0});
    d.push_back('{MINV, MINV, MINV, MINV, MAXV, MAXV, MAXV, 1});
    d.push_back('{MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, 0});
    d.push_back('{1, 0, 0, 0, 32'sh10000, -1, 1, 1});
    d.push_back('{0, 0, 0, -1, MAXV, 0, MINV, 0});
    d.push_back('{1, 1, 1, 1, 32'sh00012345, 32'sh7fff0000, -32'sh7fff0000, 0});
    d.push_back('{MINV, 0, 0, 0, MINV, MINV, MINV, 1});
    d.push_back('{ONE, ONE, 0, 0, MAXV, MAXV, 0, 0});
    d.push_back('{0, 0, MAXV, MINV, -1, -1, -1, 1});
    foreach (d[i]) push_item(d[i]);
    for (int n = 0; n < 850; n++) begin
      if (n == 300) quiet <= 1'b1;
      if (n == 450) quiet <= 1'b0;
      if (n == 600) begin
        valid_i <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk_i);
      end
      push_item(random_item());
    end
    valid_i <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
